// ===== sv/wpp_pkg.sv =====
`default_nettype none

package wpp_pkg;

   // Byte codes the parser reacts to
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // Token slots; the index saturates one past the last slot
   localparam logic [2:0] TOK_DIR = 3'd1;
   localparam logic [2:0] TOK_LON = 3'd2;
   localparam logic [2:0] TOK_LAT = 3'd3;
   localparam logic [2:0] TOK_MAX = 3'd4;

   localparam logic [1:0] BYTE_COUNT_MAX = 2'd2;

   typedef enum logic [2:0] {
      CLS_NUL,
      CLS_DELIM,
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_DIGITS,
      PH_DONE
   } conv_phase_type;

   // One classified byte as it travels from front to back
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           is_last;
      logic           frame_ok;
   } beat_type;

endpackage

`default_nettype wire

// ===== sv/wpp_if.sv =====
`default_nettype none

interface wpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_last;

   modport source (output valid, output ch, output is_last, input ready);
   modport sink (input valid, input ch, input is_last, output ready);
endinterface

interface wpp_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [7:0]  direction;
   logic [31:0] longitude;
   logic [31:0] latitude;

   modport source (output valid, output ok, output direction, output longitude,
                   output latitude, input ready);
   modport sink (input valid, input ok, input direction, input longitude,
                 input latitude, output ready);
endinterface

`default_nettype wire

// ===== sv/wpp_front.sv =====
`default_nettype none

module wpp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   wpp_req_if.sink               req_chan,
   output      logic             push_valid,
   input  wire logic             push_ready,
   output      wpp_pkg::beat_type push_beat
);
   import wpp_pkg::*;

   logic [1:0] byte_count_ff, byte_count_in;
   logic       first_ok_ff, first_ok_in;
   logic [7:0] prev_byte_ff, prev_byte_in;
   logic       first_ok_now;
   logic       accept;
   char_class_type cls;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   // Classify the byte
   always_comb begin
      if (req_chan.ch == CHAR_NUL) begin
         cls = CLS_NUL;
      end else if (req_chan.ch inside {CHAR_LPAREN, CHAR_RPAREN, CHAR_TAB, CHAR_COMMA,
                                       CHAR_SPACE}) begin
         cls = CLS_DELIM;
      end else if (req_chan.ch inside {CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR}) begin
         cls = CLS_SPACE;
      end else if (req_chan.ch == CHAR_PLUS) begin
         cls = CLS_PLUS;
      end else if (req_chan.ch == CHAR_MINUS) begin
         cls = CLS_MINUS;
      end else if (req_chan.ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
         cls = CLS_DIGIT;
      end else begin
         cls = CLS_OTHER;
      end
   end

   // Track framing: opening paren first, closing paren second to last
   assign first_ok_now = (byte_count_ff == 2'd0) ? (req_chan.ch == CHAR_LPAREN) : first_ok_ff;

   always_comb begin
      push_beat.cls      = cls;
      push_beat.digit    = req_chan.ch[3:0];
      push_beat.is_last  = req_chan.is_last;
      push_beat.frame_ok = (byte_count_ff != 2'd0) && first_ok_now &&
                           (prev_byte_ff == CHAR_RPAREN);
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      first_ok_in   = first_ok_ff;
      prev_byte_in  = prev_byte_ff;
      if (accept) begin
         if (req_chan.is_last) begin
            byte_count_in = 2'd0;
            first_ok_in   = 1'b0;
            prev_byte_in  = CHAR_NUL;
         end else begin
            first_ok_in  = first_ok_now;
            prev_byte_in = req_chan.ch;
            if (byte_count_ff < BYTE_COUNT_MAX) begin
               byte_count_in = byte_count_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 2'd0;
         first_ok_ff   <= 1'b0;
         prev_byte_ff  <= CHAR_NUL;
      end else begin
         byte_count_ff <= byte_count_in;
         first_ok_ff   <= first_ok_in;
         prev_byte_ff  <= prev_byte_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wpp_queue.sv =====
`default_nettype none

module wpp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output      logic              push_ready,
   input  wire wpp_pkg::beat_type push_beat,
   output      logic              pop_valid,
   input  wire logic              pop_ready,
   output      wpp_pkg::beat_type pop_beat
);
   import wpp_pkg::*;

   beat_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_beat   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wpp_back.sv =====
`default_nettype none

module wpp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output      logic              pop_ready,
   input  wire wpp_pkg::beat_type pop_beat,
   wpp_rsp_if.source              rsp_chan
);
   import wpp_pkg::*;

   // Tokenizer and converter state
   logic           nul_ff, nul_in;
   logic           in_tok_ff, in_tok_in;
   logic [2:0]     idx_ff, idx_in;
   conv_phase_type phase_ff, phase_in;
   logic           neg_ff, neg_in;
   logic [31:0]    acc_ff, acc_in;
   logic [31:0]    acc_mul;
   logic           store;

   // Token slots hold the magnitude and the sign; negation happens at the port
   logic [7:0]  dir_raw_ff, dir_raw_in;
   logic        dir_neg_ff, dir_neg_in;
   logic [31:0] lon_raw_ff, lon_raw_in;
   logic        lon_neg_ff, lon_neg_in;
   logic [31:0] lat_raw_ff, lat_raw_in;
   logic        lat_neg_ff, lat_neg_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff;
   logic [7:0]  rsp_dir_ff;
   logic        rsp_dir_neg_ff;
   logic [31:0] rsp_lon_ff;
   logic        rsp_lon_neg_ff;
   logic [31:0] rsp_lat_ff;
   logic        rsp_lat_neg_ff;

   logic out_free, do_pop, finish;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = !pop_beat.is_last || out_free;
   assign do_pop    = pop_valid && pop_ready;
   assign finish    = do_pop && pop_beat.is_last;

   assign acc_mul = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + {28'd0, pop_beat.digit};

   // Step the tokenizer and the converter by one byte
   always_comb begin
      nul_in     = nul_ff;
      in_tok_in  = in_tok_ff;
      idx_in     = idx_ff;
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      store      = 1'b0;
      dir_raw_in = dir_raw_ff;
      dir_neg_in = dir_neg_ff;
      lon_raw_in = lon_raw_ff;
      lon_neg_in = lon_neg_ff;
      lat_raw_in = lat_raw_ff;
      lat_neg_in = lat_neg_ff;
      if (!nul_ff) begin
         case (pop_beat.cls)
            CLS_NUL: begin
               nul_in    = 1'b1;
               in_tok_in = 1'b0;
            end
            CLS_DELIM: begin
               in_tok_in = 1'b0;
            end
            default: begin
               if (!in_tok_ff) begin
                  in_tok_in = 1'b1;
                  if (idx_ff < TOK_MAX) begin
                     idx_in = idx_ff + 3'd1;
                  end
                  phase_in = PH_SKIP;
                  neg_in   = 1'b0;
                  acc_in   = 32'd0;
               end
               case (phase_in)
                  PH_SKIP: begin
                     if (pop_beat.cls == CLS_PLUS || pop_beat.cls == CLS_MINUS) begin
                        neg_in   = (pop_beat.cls == CLS_MINUS);
                        phase_in = PH_DIGITS;
                        store    = 1'b1;
                     end else if (pop_beat.cls == CLS_DIGIT) begin
                        acc_in   = {28'd0, pop_beat.digit};
                        phase_in = PH_DIGITS;
                        store    = 1'b1;
                     end else if (pop_beat.cls != CLS_SPACE) begin
                        phase_in = PH_DONE;
                        store    = 1'b1;
                     end
                  end
                  PH_DIGITS: begin
                     if (pop_beat.cls == CLS_DIGIT) begin
                        acc_in = acc_mul;
                     end else begin
                        phase_in = PH_DONE;
                     end
                     store = 1'b1;
                  end
                  default: begin
                     store = 1'b1;
                  end
               endcase
            end
         endcase
      end
      // Write the running value into the current token's slot
      if (store) begin
         case (idx_in)
            TOK_DIR: begin
               dir_raw_in = acc_in[7:0];
               dir_neg_in = neg_in;
            end
            TOK_LON: begin
               lon_raw_in = acc_in;
               lon_neg_in = neg_in;
            end
            TOK_LAT: begin
               lat_raw_in = acc_in;
               lat_neg_in = neg_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         nul_ff     <= 1'b0;
         in_tok_ff  <= 1'b0;
         idx_ff     <= 3'd0;
         phase_ff   <= PH_SKIP;
         neg_ff     <= 1'b0;
         acc_ff     <= 32'd0;
         dir_raw_ff <= 8'd0;
         dir_neg_ff <= 1'b0;
         lon_raw_ff <= 32'd0;
         lon_neg_ff <= 1'b0;
         lat_raw_ff <= 32'd0;
         lat_neg_ff <= 1'b0;
      end else if (do_pop) begin
         nul_ff     <= nul_in;
         in_tok_ff  <= in_tok_in;
         idx_ff     <= idx_in;
         phase_ff   <= phase_in;
         neg_ff     <= neg_in;
         acc_ff     <= acc_in;
         dir_raw_ff <= dir_raw_in;
         dir_neg_ff <= dir_neg_in;
         lon_raw_ff <= lon_raw_in;
         lon_neg_ff <= lon_neg_in;
         lat_raw_ff <= lat_raw_in;
         lat_neg_ff <= lat_neg_in;
      end
   end

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the message result; zero everything on bad framing
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ok_ff      <= pop_beat.frame_ok && (idx_in == TOK_LAT);
         rsp_dir_ff     <= pop_beat.frame_ok ? dir_raw_in : 8'd0;
         rsp_dir_neg_ff <= pop_beat.frame_ok && dir_neg_in;
         rsp_lon_ff     <= pop_beat.frame_ok ? lon_raw_in : 32'd0;
         rsp_lon_neg_ff <= pop_beat.frame_ok && lon_neg_in;
         rsp_lat_ff     <= pop_beat.frame_ok ? lat_raw_in : 32'd0;
         rsp_lat_neg_ff <= pop_beat.frame_ok && lat_neg_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.ok        = rsp_ok_ff;
   assign rsp_chan.direction = rsp_dir_neg_ff ? (8'd0 - rsp_dir_ff) : rsp_dir_ff;
   assign rsp_chan.longitude = rsp_lon_neg_ff ? (32'd0 - rsp_lon_ff) : rsp_lon_ff;
   assign rsp_chan.latitude  = rsp_lat_neg_ff ? (32'd0 - rsp_lat_ff) : rsp_lat_ff;

endmodule

`default_nettype wire

// ===== sv/waypoint_message_parser_top.sv =====
// Waypoint message parser.
// req_chan carries one message byte per beat (ch) with is_last on the final
// byte. After the last byte one beat leaves on rsp_chan: ok, direction,
// longitude and latitude, taken from the first three tokens of a message
// framed as "(" ... ")" plus one trailing byte. Bad framing returns all zeros.
// Throughput is one byte per cycle: the front classifies each byte and tracks
// framing, a two-entry queue decouples it from the back, which runs the
// tokenizer and the atoi-style converter (one multiply-by-ten add per cycle).
// The last byte is held in a queue entry and its result in the output register.
// A pending result sits in the output register while further bytes of the next
// message keep flowing; only the next last byte waits for it, and the queue
// then fills and drops req_chan.ready until the receiver takes the beat.
// Synchronous reset clears framing, tokenizer state, the queue and the
// output valid flag; the block accepts bytes as soon as reset is released.
`default_nettype none

module waypoint_message_parser_top (
   input wire logic clock,
   input wire logic reset,
   wpp_req_if.sink   req_chan,
   wpp_rsp_if.source rsp_chan
);
   import wpp_pkg::*;

   logic     push_valid, push_ready;
   beat_type push_beat;
   logic     pop_valid, pop_ready;
   beat_type pop_beat;

   wpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_beat  (push_beat)
   );

   wpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_beat  (push_beat),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_beat   (pop_beat)
   );

   wpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_beat  (pop_beat),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_waypoint_message_parser_top.sv =====
`timescale 1ns / 1ps

module tb_waypoint_message_parser_top;
   import wpp_pkg::*;

   typedef logic [7:0] byte_seq_type[$];

   typedef struct packed {
      logic        ok;
      logic [7:0]  direction;
      logic [31:0] longitude;
      logic [31:0] latitude;
   } waypoint_fix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   wpp_req_if req_bus();
   wpp_rsp_if rsp_bus();

   waypoint_message_parser_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   waypoint_fix_type pending_fixes[$];
   int               fail_count = 0;
   int               bytes_sent = 0;
   bit               sender_idles = 1'b1;
   bit               sink_stalls = 1'b1;

   // Mirror of the parser state
   logic [1:0]     seen_count;
   logic           opens_with_paren;
   logic [7:0]     last_byte;
   logic           nul_hit;
   logic           in_word;
   logic [2:0]     word_idx;
   conv_phase_type num_phase;
   logic           minus;
   logic [31:0]    magnitude;
   logic [7:0]     dir_field;
   logic [31:0]    lon_field;
   logic [31:0]    lat_field;

   function automatic logic is_separator(logic [7:0] c);
      return c == CHAR_LPAREN || c == CHAR_RPAREN || c == CHAR_TAB ||
             c == CHAR_COMMA || c == CHAR_SPACE;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
             c == CHAR_FF || c == CHAR_CR;
   endfunction

   task automatic clear_parser();
      seen_count       = '0;
      opens_with_paren = 1'b0;
      last_byte        = '0;
      nul_hit          = 1'b0;
      in_word          = 1'b0;
      word_idx         = '0;
      num_phase        = PH_SKIP;
      minus            = 1'b0;
      magnitude        = '0;
      dir_field        = '0;
      lon_field        = '0;
      lat_field        = '0;
   endtask

   // Advance the mirror by one accepted byte; queue a fix on the last byte
   task automatic absorb_byte(input logic [7:0] c, input logic last);
      logic             is_digit;
      logic             store;
      logic [31:0]      val;
      waypoint_fix_type fix;
      if (seen_count == 2'd0)
         opens_with_paren = (c == CHAR_LPAREN);
      if (!nul_hit) begin
         if (c == CHAR_NUL) begin
            nul_hit = 1'b1;
            in_word = 1'b0;
         end else if (is_separator(c)) begin
            in_word = 1'b0;
         end else begin
            if (!in_word) begin
               in_word = 1'b1;
               if (word_idx < TOK_MAX)
                  word_idx++;
               num_phase = PH_SKIP;
               minus     = 1'b0;
               magnitude = '0;
            end
            is_digit = c >= CHAR_ZERO && c <= CHAR_NINE;
            store    = 1'b1;
            case (num_phase)
               PH_SKIP: begin
                  if (is_blank(c)) begin
                     store = 1'b0;
                  end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                     minus     = (c == CHAR_MINUS);
                     num_phase = PH_DIGITS;
                  end else if (is_digit) begin
                     magnitude = {28'd0, c[3:0]};
                     num_phase = PH_DIGITS;
                  end else begin
                     num_phase = PH_DONE;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit)
                     magnitude = magnitude * 32'd10 + {28'd0, c[3:0]};
                  else
                     num_phase = PH_DONE;
               end
               default: ;
            endcase
            if (store) begin
               val = minus ? (32'd0 - magnitude) : magnitude;
               case (word_idx)
                  TOK_DIR: dir_field = val[7:0];
                  TOK_LON: lon_field = val;
                  TOK_LAT: lat_field = val;
                  default: ;
               endcase
            end
         end
      end
      if (!last) begin
         last_byte = c;
         if (seen_count < BYTE_COUNT_MAX)
            seen_count++;
      end else begin
         if (seen_count >= 2'd1 && opens_with_paren && last_byte == CHAR_RPAREN) begin
            fix.ok        = (word_idx == TOK_LAT);
            fix.direction = dir_field;
            fix.longitude = lon_field;
            fix.latitude  = lat_field;
         end else begin
            fix = '0;
         end
         pending_fixes.push_back(fix);
         clear_parser();
      end
   endtask

   // Drive one beat and hold it until accepted
   task automatic send_byte(input logic [7:0] c, input logic last);
      while (sender_idles && $urandom_range(99) < 33) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.ch      <= c;
      req_bus.is_last <= last;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      absorb_byte(c, last);
      bytes_sent++;
   endtask

   task automatic send_seq(input byte_seq_type m);
      for (int i = 0; i < m.size(); i++)
         send_byte(m[i], i == m.size() - 1);
   endtask

   task automatic send_text(input string s);
      byte_seq_type m;
      for (int i = 0; i < s.len(); i++)
         m.push_back(s[i]);
      send_seq(m);
   endtask

   // Send head, then a NUL, then tail
   task automatic send_split(input string head, input string tail);
      byte_seq_type m;
      for (int i = 0; i < head.len(); i++)
         m.push_back(head[i]);
      m.push_back(CHAR_NUL);
      for (int i = 0; i < tail.len(); i++)
         m.push_back(tail[i]);
      send_seq(m);
   endtask

   // Check each result beat against the oldest expected fix
   task automatic report_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      waypoint_fix_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_fixes.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual ok=%0d dir=%0d",
                        $time, rsp_bus.ok, rsp_bus.direction);
               fail_count++;
            end else begin
               want = pending_fixes.pop_front();
               report_field("ok", {31'd0, want.ok}, {31'd0, rsp_bus.ok});
               report_field("direction", {24'd0, want.direction}, {24'd0, rsp_bus.direction});
               report_field("longitude", want.longitude, rsp_bus.longitude);
               report_field("latitude", want.latitude, rsp_bus.latitude);
            end
         end
         rsp_bus.ready <= !sink_stalls || ($urandom_range(99) >= 33);
      end
   end

   // Directed cases
   task automatic test_framing();
      send_text("(");
      send_text("(1,2,3))");
      send_text("[1,2,3)x");
      send_text("(1,2,3x)");
      send_text("()");
   endtask

   task automatic test_token_count();
      send_text("())");
      send_text("(5)!");
      send_text("(1 2\t3,4)!");
   endtask

   task automatic test_signs_and_blanks();
      send_text("(\n-7,\013+12,\015\0149z))");
      send_text("(-,+,x).");
      send_text("(7\n8,1,2).");
   endtask

   task automatic test_wrap_and_extremes();
      send_text("(255,4294967295,-2147483648).");
      send_text("(256,4294967296,99999999999999999999)\377");
      send_text("(\377,0,-0))");
   endtask

   task automatic test_nul_cut();
      send_split("(1,2", ",3).");
      send_split("(9,8,7)", "");
      send_split("", "(1,2,3))");
   endtask

   // Random message building
   function automatic logic [7:0] pick_blank();
      case ($urandom_range(3))
         0:       return CHAR_LF;
         1:       return CHAR_VT;
         2:       return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(7))
         0, 1, 2: return CHAR_COMMA;
         3, 4:    return CHAR_SPACE;
         5:       return CHAR_TAB;
         6:       return CHAR_LPAREN;
         default: return CHAR_RPAREN;
      endcase
   endfunction

   task automatic append_number(ref byte_seq_type m);
      int n_digits;
      if ($urandom_range(99) < 5) begin
         m.push_back(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(99) < 20)
         repeat ($urandom_range(1, 2)) m.push_back(pick_blank());
      if ($urandom_range(99) < 30)
         m.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
      n_digits = ($urandom_range(99) < 15) ? $urandom_range(5, 14) : $urandom_range(1, 4);
      repeat (n_digits) m.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(99) < 15)
         m.push_back(8'($urandom_range(1, 255)));
   endtask

   task automatic build_waypoint(ref byte_seq_type m);
      int n_tok;
      m.delete();
      m.push_back(CHAR_LPAREN);
      if ($urandom_range(99) < 30)
         m.push_back(pick_separator());
      n_tok = ($urandom_range(99) < 80) ? 3 : $urandom_range(0, 5);
      for (int t = 0; t < n_tok; t++) begin
         if (t > 0)
            repeat ($urandom_range(1, 2)) m.push_back(pick_separator());
         append_number(m);
      end
      m.push_back(CHAR_RPAREN);
      m.push_back(8'($urandom_range(255)));
      if ($urandom_range(99) < 6)
         m.insert($urandom_range(m.size() - 1), CHAR_NUL);
   endtask

   task automatic build_message(ref byte_seq_type m);
      int kind;
      int cut;
      kind = $urandom_range(99);
      if (kind < 70) begin
         build_waypoint(m);
      end else if (kind < 85) begin
         // break the framing of an otherwise good message
         build_waypoint(m);
         case ($urandom_range(3))
            0: m[0] = 8'($urandom_range(255));
            1: m[m.size() - 2] = 8'($urandom_range(255));
            2: begin
               m.delete();
               m.push_back(CHAR_LPAREN);
            end
            default: begin
               cut = $urandom_range(1, m.size());
               while (m.size() > cut)
                  void'(m.pop_back());
            end
         endcase
      end else begin
         m.delete();
         repeat ($urandom_range(1, 6)) m.push_back(8'($urandom_range(255)));
         if ($urandom_range(1))
            m[0] = CHAR_LPAREN;
      end
   endtask

   task automatic test_random_traffic(input int budget);
      byte_seq_type m;
      int           stop_at;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         build_message(m);
         send_seq(m);
      end
   endtask

   initial begin : stimulus
      int waited;
      req_bus.valid   = 1'b0;
      req_bus.ch      = '0;
      req_bus.is_last = 1'b0;
      rsp_bus.ready   = 1'b0;
      clear_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_framing();
      test_token_count();
      test_signs_and_blanks();
      test_wrap_and_extremes();
      test_nul_cut();
      test_random_traffic(750);
      // full-rate stretch with no gaps on either side
      sender_idles = 1'b0;
      sink_stalls  = 1'b0;
      test_random_traffic(400);
      sender_idles = 1'b1;
      sink_stalls  = 1'b1;
      test_random_traffic(450);
      req_bus.valid <= 1'b0;

      // drain outstanding results
      waited = 0;
      while (pending_fixes.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (pending_fixes.size() != 0) begin
         $display("%0t: missing results: expected %0d more, actual 0",
                  $time, pending_fixes.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("waypoint_message_parser_top regression: pass");
      end else begin
         $display("waypoint_message_parser_top regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("waypoint_message_parser_top regression: fail");
      $finish;
   end

endmodule
